>>> rtl/core/tgs_pkg.sv
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared types and constants of the trilinear grid sampler: field widths,
// register and operation codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tgs_pkg;

  localparam int SIZE_W     = 5;   // grid size register width
  localparam int CELL_IDX_W = 12;  // cell_index field width
  localparam int CELL_VAL_W = 16;  // cell_value field width
  localparam int DENS_W     = 16;  // density result width
  localparam int CFG_IDX_W  = 2;   // configuration register index width
  localparam int LIN_BITS   = 15;  // linear index before wrap (max 29790)
  localparam int CELL_CODE_W = 3;  // {z, y, x} corner select

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // operation codes
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // last corner of the eight
  localparam logic [CELL_CODE_W-1:0] CELL_LAST = 3'd7;

  typedef struct packed {
    logic                   wr;        // write one grid cell
    logic                   load;      // capture a query
    logic                   axis;      // per-axis index and weight step
    logic                   offs;      // linear offsets and yz weights step
    logic                   issue;     // start one corner read
    logic [CELL_CODE_W-1:0] corner;    // corner being started
    logic                   last;      // corner is the eighth
    logic                   out_load;  // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_outside;  // presented query point is outside the box
    logic sum_done;    // eighth product is being accumulated
    logic pipe_busy;   // a corner read is still in flight
  } dp_status_t;

endpackage

>>> rtl/core/tgs_ram.sv
// ----------------------------------------------------------------------------
// tgs_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module tgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/tgs_ctrl.sv
// ----------------------------------------------------------------------------
// tgs_ctrl
// Sequencer of the grid sampler: accepts items, steps a query through the
// axis, offset, corner-read and drain phases, and owns the result valid.
// ----------------------------------------------------------------------------
module tgs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 operation,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  tgs_pkg::dp_status_t  status,
  output tgs_pkg::ctrl_cmd_t   cmd
);

  import tgs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_AXIS  = 6'b000010,
    ST_OFFS  = 6'b000100,
    ST_ISSUE = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                 state, state_next;
  logic [CELL_CODE_W-1:0] cell_cnt, cell_cnt_next;
  logic                   m_valid, m_valid_next;
  logic                   accept;
  logic                   can_load;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign can_load = !m_valid || m_tready;
  assign m_tvalid = m_valid;

  always_comb begin
    state_next    = state;
    cell_cnt_next = cell_cnt;
    cmd           = '0;
    cmd.corner    = cell_cnt;
    cmd.last      = (cell_cnt == CELL_LAST);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = status.in_outside ? ST_DONE : ST_AXIS;
          end
        end
      end
      ST_AXIS: begin
        cmd.axis   = 1'b1;
        state_next = ST_OFFS;
      end
      ST_OFFS: begin
        cmd.offs      = 1'b1;
        cell_cnt_next = '0;
        state_next    = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd.issue     = 1'b1;
        cell_cnt_next = cell_cnt + CELL_CODE_W'(1);
        if (cell_cnt == CELL_LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.sum_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (can_load) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_next = m_valid;
    if (cmd.out_load) begin
      m_valid_next = 1'b1;
    end else if (m_tready) begin
      m_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cell_cnt <= '0;
      m_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      cell_cnt <= cell_cnt_next;
      m_valid  <= m_valid_next;
    end
  end

endmodule

>>> rtl/core/tgs_datapath.sv
// ----------------------------------------------------------------------------
// tgs_datapath
// Size registers, per-axis index and weight math, the corner address
// pipeline with index wrap, the grid RAM, the weighted accumulation and the
// result register.
// ----------------------------------------------------------------------------
module tgs_datapath #(
  parameter int GRID_CELLS      = 4096,
  parameter int DENSITY_BITS    = 16,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgs_pkg::SIZE_W-1:0]          cfg_data,
  input  logic [tgs_pkg::CELL_IDX_W-1:0]      cell_index,
  input  logic [tgs_pkg::CELL_VAL_W-1:0]      cell_value,
  input  logic signed [COORD_FRAC_BITS+1:0]   coord_x,
  input  logic signed [COORD_FRAC_BITS+1:0]   coord_y,
  input  logic signed [COORD_FRAC_BITS+1:0]   coord_z,
  input  tgs_pkg::ctrl_cmd_t                  cmd,
  output tgs_pkg::dp_status_t                 status,
  output logic [tgs_pkg::DENS_W-1:0]          density,
  output logic                                outside
);

  import tgs_pkg::*;

  localparam int F      = COORD_FRAC_BITS;
  localparam int CB     = F + 2;
  localparam int AW     = $clog2(GRID_CELLS);
  localparam int SW2    = 2 * SIZE_W;
  localparam int SP_W   = F + SIZE_W;
  // reciprocal of the grid depth, exact quotient for any linear index
  localparam int SH     = LIN_BITS + AW + 1;
  localparam int PR_W   = LIN_BITS + SH;
  localparam logic [SH-1:0] RECIP =
    SH'(((64'd1 << SH) + 64'(GRID_CELLS) - 64'd1) / 64'(GRID_CELLS));
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam int WZY_W  = 2 * F + 2;
  localparam int P1_W   = DENSITY_BITS + WZY_W;
  localparam int P2_W   = P1_W + F + 1;
  localparam int ACC_W  = ((DENSITY_BITS > DENS_W) ? DENSITY_BITS : DENS_W) + 3 * F + 3;

  // configuration
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [SIZE_W-1:0] eff [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // a size of zero acts as one
  assign eff[0] = (size_x == '0) ? SIZE_W'(1) : size_x;
  assign eff[1] = (size_y == '0) ? SIZE_W'(1) : size_y;
  assign eff[2] = (size_z == '0) ? SIZE_W'(1) : size_z;

  // query capture
  logic [F-1:0] cf [3];
  logic         outside_q;

  assign status.in_outside = (|coord_x[CB-1:F]) || (|coord_y[CB-1:F]) ||
                             (|coord_z[CB-1:F]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cf[0]     <= coord_x[F-1:0];
      cf[1]     <= coord_y[F-1:0];
      cf[2]     <= coord_z[F-1:0];
      outside_q <= status.in_outside;
    end
  end

  // per-axis lower/upper index and weights
  logic [SIZE_W-1:0] szm1   [3];
  logic [SP_W-1:0]   sprod  [3];
  logic [SIZE_W-1:0] lraw   [3];
  logic [SIZE_W-1:0] lo_n   [3];
  logic [SIZE_W-1:0] up_n   [3];
  logic [F:0]        wu_n   [3];
  logic [F:0]        wl_n   [3];
  logic [SIZE_W-1:0] idx    [3][2];
  logic [F:0]        wgt    [3][2];
  logic [SW2-1:0]    sxsy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      szm1[i]  = eff[i] - SIZE_W'(1);
      sprod[i] = SP_W'(cf[i]) * SP_W'(szm1[i]);
      lraw[i]  = sprod[i][SP_W-1:F];
      lo_n[i]  = (lraw[i] > szm1[i]) ? szm1[i] : lraw[i];
      up_n[i]  = ((SIZE_W + 1)'(lo_n[i]) + (SIZE_W + 1)'(1) < (SIZE_W + 1)'(eff[i])) ?
                 lo_n[i] + SIZE_W'(1) : szm1[i];
      wu_n[i]  = {1'b0, sprod[i][F-1:0]};
      wl_n[i]  = ONE - wu_n[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.axis) begin
      for (int i = 0; i < 3; i++) begin
        idx[i][0] <= lo_n[i];
        idx[i][1] <= up_n[i];
        wgt[i][0] <= wl_n[i];
        wgt[i][1] <= wu_n[i];
      end
      sxsy <= SW2'(eff[0]) * SW2'(eff[1]);
    end
  end

  // linear offsets per axis and the yz weight products
  logic [LIN_BITS-1:0] xo  [2];
  logic [LIN_BITS-1:0] yo  [2];
  logic [LIN_BITS-1:0] zo  [2];
  logic [WZY_W-1:0]    wzy [2][2];

  always_ff @(posedge clk) begin
    if (cmd.offs) begin
      for (int k = 0; k < 2; k++) begin
        xo[k] <= LIN_BITS'(idx[0][k]);
        yo[k] <= LIN_BITS'(SW2'(eff[0]) * SW2'(idx[1][k]));
        zo[k] <= LIN_BITS'(LIN_BITS'(sxsy) * LIN_BITS'(idx[2][k]));
        for (int j = 0; j < 2; j++) begin
          wzy[k][j] <= WZY_W'(wgt[2][k]) * WZY_W'(wgt[1][j]);
        end
      end
    end
  end

  // corner pipeline: sum, reciprocal multiply, quotient times depth,
  // RAM read, yz weight, x weight, accumulate
  logic                   vld_a, vld_b, vld_c, vld_d, vld_e, vld_f;
  logic [CELL_CODE_W-1:0] cell_a, cell_b, cell_c, cell_d;
  logic                   last_a, last_b, last_c, last_d, last_e, last_f;
  logic                   xa_e;
  logic [LIN_BITS-1:0]    lin_a, lin_b, lin_c;
  logic [PR_W-1:0]        prod_b;
  logic [LIN_BITS-1:0]    quot_b;
  logic [LIN_BITS-1:0]    qg_c;
  logic [AW-1:0]          rd_addr;
  logic [DENSITY_BITS-1:0] rdata;
  logic [P1_W-1:0]        p1_e;
  logic [P2_W-1:0]        p2_f;
  logic [ACC_W-1:0]       acc;

  assign quot_b  = prod_b[PR_W-1:SH];
  assign rd_addr = AW'(lin_c - qg_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
      vld_e <= 1'b0;
      vld_f <= 1'b0;
    end else begin
      vld_a <= cmd.issue;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_d <= vld_c;
      vld_e <= vld_d;
      vld_f <= vld_e;
    end
  end

  always_ff @(posedge clk) begin
    lin_a  <= xo[cmd.corner[0]] + yo[cmd.corner[1]] + zo[cmd.corner[2]];
    cell_a <= cmd.corner;
    last_a <= cmd.last;

    prod_b <= PR_W'(lin_a) * PR_W'(RECIP);
    lin_b  <= lin_a;
    cell_b <= cell_a;
    last_b <= last_a;

    qg_c   <= LIN_BITS'(32'(quot_b) * 32'(GRID_CELLS));
    lin_c  <= lin_b;
    cell_c <= cell_b;
    last_c <= last_b;

    cell_d <= cell_c;
    last_d <= last_c;

    p1_e   <= P1_W'(rdata) * P1_W'(wzy[cell_d[2]][cell_d[1]]);
    xa_e   <= cell_d[0];
    last_e <= last_d;

    p2_f   <= P2_W'(p1_e) * P2_W'(wgt[0][xa_e]);
    last_f <= last_e;
  end

  assign status.sum_done  = vld_f && last_f;
  assign status.pipe_busy = vld_a || vld_b || vld_c || vld_d || vld_e || vld_f;

  always_ff @(posedge clk) begin
    if (cmd.axis) begin
      acc <= '0;
    end else if (vld_f) begin
      acc <= acc + ACC_W'(p2_f);
    end
  end

  // grid memory; writes beyond the depth are dropped
  logic          ram_we;
  logic [AW-1:0] ram_addr;

  assign ram_we   = cmd.wr && (32'(cell_index) < 32'(GRID_CELLS));
  assign ram_addr = cmd.wr ? AW'(cell_index) : rd_addr;

  tgs_ram #(
    .WIDTH (DENSITY_BITS),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (DENSITY_BITS'(cell_value)),
    .rdata (rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      density <= outside_q ? '0 : acc[3*F +: DENS_W];
      outside <= outside_q;
    end
  end

endmodule

>>> rtl/core/trilinear_grid_sampler.sv
// ----------------------------------------------------------------------------
// trilinear_grid_sampler
// Density grid in one RAM; write items store a cell, query items return the
// trilinear blend of the eight cells around a box-local point.
//
//   channel  dir  handshake          contents
//   s_*      in   s_tvalid/s_tready  tuser: operation; tdata: index, value, xyz
//   m_*      out  m_tvalid/m_tready  tuser: outside; tdata: density
//   cfg_*    in   cfg_we             size_x, size_y, size_z by index 0..2
//
// A query outside the box goes straight to the done state, which loads its
// result into the output register; one inside passes through two setup steps,
// the eight corner reads issued one a cycle through the single RAM port, and
// the six-stage address, multiply and accumulate pipeline draining behind them.
// The next item is taken once the result is in the output register. Reset
// sets all sizes to 16 and leaves the grid contents undefined. A stalled
// result holds the output register; a finished query then waits for it.
// ----------------------------------------------------------------------------
module trilinear_grid_sampler #(
  parameter int GRID_CELLS      = 4096,
  parameter int DENSITY_BITS    = 16,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // cell_index, cell_value, coord_x, coord_y, coord_z, zero pad
  input  logic [((tgs_pkg::CELL_IDX_W + tgs_pkg::CELL_VAL_W
                  + 3 * (COORD_FRAC_BITS + 2) + 7) / 8) * 8 - 1:0] s_tdata,
  // operation
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // density
  output logic [tgs_pkg::DENS_W-1:0]        m_tdata,
  // outside
  output logic [0:0]                        m_tuser,
  input  logic                              cfg_we,
  input  logic [tgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgs_pkg::SIZE_W-1:0]        cfg_data
);

  import tgs_pkg::*;

  localparam int CB    = COORD_FRAC_BITS + 2;
  localparam int OFF_V = CELL_IDX_W;
  localparam int OFF_X = CELL_IDX_W + CELL_VAL_W;
  localparam int OFF_Y = OFF_X + CB;
  localparam int OFF_Z = OFF_Y + CB;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .operation (s_tuser[0]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tgs_datapath #(
    .GRID_CELLS      (GRID_CELLS),
    .DENSITY_BITS    (DENSITY_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_index (s_tdata[CELL_IDX_W-1:0]),
    .cell_value (s_tdata[OFF_V +: CELL_VAL_W]),
    .coord_x    (s_tdata[OFF_X +: CB]),
    .coord_y    (s_tdata[OFF_Y +: CB]),
    .coord_z    (s_tdata[OFF_Z +: CB]),
    .cmd        (cmd),
    .status     (status),
    .density    (m_tdata),
    .outside    (m_tuser[0])
  );

  // no corner read may be in flight while new items are taken
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !status.pipe_busy)
    else $error("corner pipeline busy while accepting items");

  // the result is loaded only after the last corner has been summed
  a_load_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.pipe_busy)
    else $error("result loaded with corner reads in flight");

  // an outside point always reports zero density
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("outside result with nonzero density");

  // the last product arrives only while no new corner is being started
  a_done_no_issue: assert property (@(posedge clk) disable iff (rst)
    status.sum_done |-> !cmd.issue && !cmd.load)
    else $error("accumulation finished during issue");

endmodule
